>>> sv/prefix_tree_bit_decoder_macros.svh
// Assertion macros used by the port-level checker of the prefix tree bit decoder.
`ifndef PREFIX_TREE_BIT_DECODER_MACROS_SVH
`define PREFIX_TREE_BIT_DECODER_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define PTBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PTBD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ptbd_pkg.sv
// Shared codes and control/status types of the prefix tree bit decoder.
package ptbd_pkg;

  // Input beat kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_BIT   = 2'd2;

  // Result error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EARLY = 2'd2;
  localparam logic [1:0] ERR_EXTRA = 2'd3;

  // Tree byte that marks an internal node
  localparam logic [7:0] INTERNAL_MARK = 8'd42;

  typedef struct packed {
    logic accept;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_busy;
  } status_t;

endpackage

>>> sv/ptbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/ptbd_ctrl.sv
// Controller state machine: accept a beat, then execute it once the result can be placed.
module ptbd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptbd_pkg::status_t  status,
  output ptbd_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    state_nxt  = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold while a result has nowhere to go
        cmd.commit = !(status.has_result && status.out_busy);
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> sv/ptbd_dp.sv
// Datapath: node tables, pending stack, walk state and output register.
module ptbd_dp #(
  parameter int MAX_NODES   = 256,
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ptbd_pkg::cmd_t     cmd,
  output ptbd_pkg::status_t  status,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_tree_symbol,
  input  logic               in_code_bit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_decoded_symbol,
  output logic [1:0]         out_error_code
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int CW = IW + 9;

  // Latched beat
  logic [1:0]    kind_r;
  logic [7:0]    sym_r;
  logic          bit_r;

  // Tree build and walk state
  logic [NW-1:0] nodes_r, nodes_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [IW-1:0] top_node_r, top_node_nxt;
  logic          top_ldone_r, top_ldone_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic          done_r, done_nxt;
  logic          root_leaf_r, root_leaf_nxt;
  logic [7:0]    root_sym_r, root_sym_nxt;

  // Output register
  logic          out_valid_r;
  logic [7:0]    out_sym_r;
  logic [1:0]    out_err_r;

  logic          res_valid;
  logic [7:0]    res_sym;
  logic [1:0]    res_err;

  logic          left_we, right_we, stack_we;
  logic [CW-1:0] left_rdata, right_rdata, child, new_entry;
  logic [IW-1:0] stack_rdata;
  logic [IW-1:0] new_idx;
  logic [LW-1:0] lvl_m1, lvl_m2, level_after;
  logic          is_internal;

  assign is_internal = (sym_r == ptbd_pkg::INTERNAL_MARK);
  assign new_idx     = nodes_r[IW-1:0];
  assign new_entry   = {new_idx, !is_internal, sym_r};
  assign lvl_m1      = level_r - LW'(1);
  assign lvl_m2      = level_r - LW'(2);
  assign level_after = (level_r != '0 && top_ldone_r) ? lvl_m1 : level_r;
  assign child       = bit_r ? right_rdata : left_rdata;

  // Each table entry holds the child's index, leaf flag and symbol
  ptbd_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_left_ram (
    .clk   (clk),
    .we    (left_we && cmd.commit),
    .waddr (top_node_r),
    .wdata (new_entry),
    .re    (cmd.accept),
    .raddr (cur_r),
    .rdata (left_rdata)
  );

  ptbd_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_right_ram (
    .clk   (clk),
    .we    (right_we && cmd.commit),
    .waddr (top_node_r),
    .wdata (new_entry),
    .re    (cmd.accept),
    .raddr (cur_r),
    .rdata (right_rdata)
  );

  // Entries below the top of the pending stack; the top lives in registers
  ptbd_ram #(.WIDTH(IW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we && cmd.commit),
    .waddr (lvl_m1[SW-1:0]),
    .wdata (top_node_r),
    .re    (cmd.accept),
    .raddr (lvl_m2[SW-1:0]),
    .rdata (stack_rdata)
  );

  always_comb begin
    nodes_nxt     = nodes_r;
    level_nxt     = level_r;
    top_node_nxt  = top_node_r;
    top_ldone_nxt = top_ldone_r;
    cur_nxt       = cur_r;
    done_nxt      = done_r;
    root_leaf_nxt = root_leaf_r;
    root_sym_nxt  = root_sym_r;
    res_valid     = 1'b0;
    res_sym       = 8'd0;
    res_err       = ptbd_pkg::ERR_OK;
    left_we       = 1'b0;
    right_we      = 1'b0;
    stack_we      = 1'b0;
    case (kind_r)
      ptbd_pkg::KIND_CLEAR: begin
        nodes_nxt = '0;
        level_nxt = '0;
        cur_nxt   = '0;
        done_nxt  = 1'b0;
      end
      ptbd_pkg::KIND_LOAD: begin
        if (done_r) begin
          res_valid = 1'b1;
          res_err   = ptbd_pkg::ERR_EXTRA;
        end else if (nodes_r >= NW'(MAX_NODES)) begin
          res_valid = 1'b1;
          res_err   = ptbd_pkg::ERR_FULL;
        end else if (is_internal && level_after >= LW'(STACK_DEPTH)) begin
          res_valid = 1'b1;
          res_err   = ptbd_pkg::ERR_FULL;
        end else begin
          nodes_nxt = nodes_r + NW'(1);
          if (nodes_r == '0) begin
            root_leaf_nxt = !is_internal;
            root_sym_nxt  = sym_r;
          end
          // attach to the top pending node: left first, then right and pop
          if (level_r != '0) begin
            if (!top_ldone_r) begin
              left_we       = 1'b1;
              top_ldone_nxt = 1'b1;
            end else begin
              right_we      = 1'b1;
              level_nxt     = lvl_m1;
              top_node_nxt  = stack_rdata;
              top_ldone_nxt = 1'b1;
            end
          end
          if (is_internal) begin
            // spill the old top only when it stays pending
            stack_we      = (level_r != '0) && !top_ldone_r;
            top_node_nxt  = new_idx;
            top_ldone_nxt = 1'b0;
            level_nxt     = level_after + LW'(1);
          end
          if (level_nxt == '0) begin
            done_nxt = 1'b1;
            cur_nxt  = '0;
          end
        end
      end
      ptbd_pkg::KIND_BIT: begin
        if (!done_r) begin
          res_valid = 1'b1;
          res_err   = ptbd_pkg::ERR_EARLY;
        end else if (root_leaf_r) begin
          res_valid = 1'b1;
          res_sym   = root_sym_r;
          cur_nxt   = '0;
        end else if (child[8]) begin
          res_valid = 1'b1;
          res_sym   = child[7:0];
          cur_nxt   = '0;
        end else begin
          cur_nxt = child[CW-1:9];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      sym_r  <= in_tree_symbol;
      bit_r  <= in_code_bit;
    end
    if (cmd.commit) begin
      top_node_r  <= top_node_nxt;
      top_ldone_r <= top_ldone_nxt;
      root_leaf_r <= root_leaf_nxt;
      root_sym_r  <= root_sym_nxt;
    end
    if (cmd.commit && res_valid) begin
      out_sym_r <= res_sym;
      out_err_r <= res_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r     <= '0;
      level_r     <= '0;
      cur_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        nodes_r <= nodes_nxt;
        level_r <= level_nxt;
        cur_r   <= cur_nxt;
        done_r  <= done_nxt;
      end
      if (cmd.commit && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.has_result = res_valid;
  assign status.out_busy   = out_valid_r && out_stall;

  assign out_valid          = out_valid_r;
  assign out_decoded_symbol = out_sym_r;
  assign out_error_code     = out_err_r;

endmodule

>>> sv/prefix_tree_bit_decoder.sv
// Top level of the prefix tree bit decoder: controller plus datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per operation:
//   in_kind selects clear, load one preorder tree byte, or one code bit.
//   A tree byte of 42 is an internal node, anything else is a leaf.
//   Result channel (out_valid / out_stall) carries decoded symbols and
//   error reports (table full, bit before tree complete, extra tree byte);
//   error beats carry a zero symbol. Clears and plain loads give no beat.
// Timing:
//   A beat is taken in the idle state and executed in the execute state, which
//   can hold; no new beat is taken until the last one is through. Execute is
//   needed for the registered read of the child table at the current node.
//   A result is written to the output register when its beat commits.
//   A finished result waits in the output register while the next beat is
//   taken; a beat that has its own result holds in execute until that
//   register frees up, and in_stall stays high meanwhile.
// Reset:
//   rst_n (synchronous) empties the tree, returns the walk to the root and
//   drops any pending result. Table contents are not cleared; only written
//   entries are ever read.
module prefix_tree_bit_decoder #(
  parameter int MAX_NODES   = 256,
  parameter int STACK_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_tree_symbol,
  input  logic       in_code_bit,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_decoded_symbol,
  output logic [1:0] out_error_code
);

  ptbd_pkg::cmd_t    cmd;
  ptbd_pkg::status_t status;

  // Sequencer: idle -> execute -> idle
  ptbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Tables, pending stack, walk pointer and output register
  ptbd_dp #(
    .MAX_NODES   (MAX_NODES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_kind            (in_kind),
    .in_tree_symbol     (in_tree_symbol),
    .in_code_bit        (in_code_bit),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_decoded_symbol (out_decoded_symbol),
    .out_error_code     (out_error_code)
  );

endmodule

>>> sv/ptbd_checker.sv
// Port-level checker for the prefix tree bit decoder and its bind.
`include "prefix_tree_bit_decoder_macros.svh"

module ptbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_kind,
  input logic [7:0] in_tree_symbol,
  input logic       in_code_bit,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_decoded_symbol,
  input logic [1:0] out_error_code
);

  // A stalled result beat holds
  `PTBD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_decoded_symbol) && $stable(out_error_code), "result beat changed under stall")

  // One beat at a time: busy the cycle after a beat is taken
  `PTBD_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "beat taken while executing")

  // Error beats carry a zero symbol
  `PTBD_ASSERT(a_err_zero_sym, out_valid && out_error_code != ptbd_pkg::ERR_OK |-> out_decoded_symbol == 8'd0, "error beat with nonzero symbol")

  // A clear gives no result beat
  `PTBD_ASSERT(a_clear_silent, in_valid && !in_stall && in_kind == ptbd_pkg::KIND_CLEAR && !out_valid |-> ##3 !out_valid, "clear produced a result")

  // Reset drops any pending result
  `PTBD_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result visible after reset")

endmodule

bind prefix_tree_bit_decoder ptbd_checker u_ptbd_checker (.*);

>>> test/prefix_tree_bit_decoder_checker.sv
// Checker for the prefix tree bit decoder: tracks the tree, predicts results, compares beats.
`timescale 1ns / 100ps

module prefix_tree_bit_decoder_checker #(
  parameter int MAX_NODES   = 256,
  parameter int STACK_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_tree_symbol,
  input  logic       in_code_bit,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_decoded_symbol,
  input  logic [1:0] out_error_code,
  output int         mismatches,
  output int         results_due
);

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] err;
  } decode_result_t;

  decode_result_t results_q[$];

  // Own copy of the node table and the pending-node stack
  logic [7:0] sym_table [MAX_NODES];
  bit         leaf_table[MAX_NODES];
  int         left_of   [MAX_NODES];
  int         right_of  [MAX_NODES];
  int         pend_node [STACK_DEPTH];
  bit         pend_left_done[STACK_DEPTH];
  int         depth_level;
  int         node_count;
  int         walk_node;
  bit         complete;

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_result(input logic [7:0] s, input logic [1:0] e);
    decode_result_t r;
    r.symbol = s;
    r.err    = e;
    results_q.push_back(r);
  endtask

  task automatic empty_tree();
    depth_level = 0;
    node_count  = 0;
    walk_node   = 0;
    complete    = 1'b0;
  endtask

  task automatic grow_tree(input logic [7:0] sym);
    bit internal;
    int level_after;
    int idx;
    internal = (sym == ptbd_pkg::INTERNAL_MARK);
    if (complete) begin
      queue_result(8'd0, ptbd_pkg::ERR_EXTRA);
    end else if (node_count >= MAX_NODES) begin
      queue_result(8'd0, ptbd_pkg::ERR_FULL);
    end else begin
      level_after = depth_level;
      if (depth_level > 0 && pend_left_done[depth_level-1]) level_after = depth_level - 1;
      if (internal && level_after >= STACK_DEPTH) begin
        queue_result(8'd0, ptbd_pkg::ERR_FULL);
      end else begin
        idx = node_count;
        node_count++;
        sym_table[idx]  = sym;
        leaf_table[idx] = !internal;
        left_of[idx]    = 0;
        right_of[idx]   = 0;
        // attach to the top pending node: left first, then right and pop
        if (depth_level > 0) begin
          if (!pend_left_done[depth_level-1]) begin
            left_of[pend_node[depth_level-1]] = idx;
            pend_left_done[depth_level-1]     = 1'b1;
          end else begin
            right_of[pend_node[depth_level-1]] = idx;
            depth_level--;
          end
        end
        if (internal) begin
          pend_node[depth_level]      = idx;
          pend_left_done[depth_level] = 1'b0;
          depth_level++;
        end
        if (depth_level == 0) begin
          complete  = 1'b1;
          walk_node = 0;
        end
      end
    end
  endtask

  task automatic walk_tree(input logic cb);
    int next_node;
    if (!complete) begin
      queue_result(8'd0, ptbd_pkg::ERR_EARLY);
    end else if (leaf_table[0]) begin
      walk_node = 0;
      queue_result(sym_table[0], ptbd_pkg::ERR_OK);
    end else begin
      next_node = cb ? right_of[walk_node] : left_of[walk_node];
      if (next_node >= MAX_NODES) next_node = 0;
      if (leaf_table[next_node]) begin
        walk_node = 0;
        queue_result(sym_table[next_node], ptbd_pkg::ERR_OK);
      end else begin
        walk_node = next_node;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_tree();
      results_q.delete();
    end else begin
      if ($isunknown(out_valid)) report_mismatch("out_valid is unknown");
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (results_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: symbol %0d error %0d",
                                    out_decoded_symbol, out_error_code));
        end else begin
          if (out_decoded_symbol !== results_q[0].symbol)
            report_mismatch($sformatf("decoded_symbol got %0d expected %0d",
                                      out_decoded_symbol, results_q[0].symbol));
          if (out_error_code !== results_q[0].err)
            report_mismatch($sformatf("error_code got %0d expected %0d",
                                      out_error_code, results_q[0].err));
          void'(results_q.pop_front());
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        case (in_kind)
          ptbd_pkg::KIND_CLEAR: empty_tree();
          ptbd_pkg::KIND_LOAD:  grow_tree(in_tree_symbol);
          ptbd_pkg::KIND_BIT:   walk_tree(in_code_bit);
          default: ;
        endcase
      end
    end
    results_due = results_q.size();
  end

endmodule

>>> test/prefix_tree_bit_decoder_tb.sv
// Testbench top for the prefix tree bit decoder: clock, reset, beat stimulus and verdict.
`timescale 1ns / 100ps

module prefix_tree_bit_decoder_tb;

  localparam int NODE_LIMIT   = 256;
  localparam int STACK_LIMIT  = 128;
  localparam int ITEM_TARGET  = 1700;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  // Kind code that the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [1:0] in_kind        = ptbd_pkg::KIND_CLEAR;
  logic [7:0] in_tree_symbol = 8'd0;
  logic       in_code_bit    = 1'b0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] out_decoded_symbol;
  logic [1:0] out_error_code;

  int         mismatches;
  int         results_due;
  int         items_sent  = 0;
  int         cycle_count = 0;
  bit         idle_on     = 1'b1;
  logic [7:0] preorder_q[$];

  prefix_tree_bit_decoder #(
    .MAX_NODES  (NODE_LIMIT),
    .STACK_DEPTH(STACK_LIMIT)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_tree_symbol    (in_tree_symbol),
    .in_code_bit       (in_code_bit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_decoded_symbol(out_decoded_symbol),
    .out_error_code    (out_error_code)
  );

  prefix_tree_bit_decoder_checker #(
    .MAX_NODES  (NODE_LIMIT),
    .STACK_DEPTH(STACK_LIMIT)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_tree_symbol    (in_tree_symbol),
    .in_code_bit       (in_code_bit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_decoded_symbol(out_decoded_symbol),
    .out_error_code    (out_error_code),
    .mismatches        (mismatches),
    .results_due       (results_due)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the result side at random; hold it open during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 28);
  end

  // Hard stop: a hung handshake ends here as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("prefix_tree_bit_decoder test failed");
    $finish;
  end

  // Present one beat and hold it until the block takes it. A gap, when drawn,
  // drops valid first; otherwise valid stays high.
  task automatic send_beat(input logic [1:0] kind, input logic [7:0] sym, input logic cb);
    if (idle_on && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 28) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_tree_symbol <= sym;
    in_code_bit    <= cb;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // Unused fields of each beat carry random values.
  task automatic clear_beat();
    send_beat(ptbd_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic load_beat(input logic [7:0] sym);
    send_beat(ptbd_pkg::KIND_LOAD, sym, 1'($urandom_range(1)));
  endtask

  task automatic bit_beat(input logic cb);
    send_beat(ptbd_pkg::KIND_BIT, 8'($urandom), cb);
  endtask

  function automatic logic [7:0] leaf_byte();
    logic [7:0] s;
    s = 8'($urandom);
    while (s == ptbd_pkg::INTERNAL_MARK) s = 8'($urandom);
    return s;
  endfunction

  // Build a well-formed preorder tree of at most target nodes. Track open
  // child slots: an internal node fills one and opens two, a leaf fills one.
  task automatic build_preorder(input int target);
    int open_slots;
    int p_internal;
    preorder_q.delete();
    open_slots = 1;
    p_internal = $urandom_range(30, 85);
    while (open_slots > 0) begin
      if (preorder_q.size() + open_slots + 2 <= target && $urandom_range(99) < p_internal) begin
        preorder_q.push_back(ptbd_pkg::INTERNAL_MARK);
        open_slots++;
      end else begin
        preorder_q.push_back(leaf_byte());
        open_slots--;
      end
    end
  endtask

  initial begin
    int pick;
    int cut;
    int target;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: early bit, ignored kind, single-leaf tree, extra symbol,
    // a small full tree walked both ways, clear in the middle of a walk.
    bit_beat(1'b0);
    send_beat(KIND_UNUSED, 8'hFF, 1'b1);
    load_beat(8'hFF);
    bit_beat(1'b1);
    bit_beat(1'b0);
    load_beat(8'h00);
    clear_beat();
    load_beat(ptbd_pkg::INTERNAL_MARK);
    load_beat(8'h00);
    load_beat(ptbd_pkg::INTERNAL_MARK);
    load_beat(8'h2B);
    load_beat(8'h29);
    bit_beat(1'b0);
    bit_beat(1'b1);
    bit_beat(1'b1);
    bit_beat(1'b1);
    bit_beat(1'b0);
    bit_beat(1'b1);
    clear_beat();
    load_beat(ptbd_pkg::INTERNAL_MARK);
    bit_beat(1'b1);
    load_beat(8'h80);
    load_beat(8'h7F);
    bit_beat(1'b0);
    load_beat(ptbd_pkg::INTERNAL_MARK);

    // Deep left chain: overflow the stack, then fill the table and overflow it.
    clear_beat();
    repeat (STACK_LIMIT + 1) load_beat(ptbd_pkg::INTERNAL_MARK);
    repeat (NODE_LIMIT - STACK_LIMIT + 1) load_beat(leaf_byte());
    load_beat(ptbd_pkg::INTERNAL_MARK);
    bit_beat(1'b1);

    // Random episodes: mostly clean trees with random walks, some broken loads,
    // single-leaf trees and raw noise.
    while (items_sent < ITEM_TARGET) begin
      idle_on = !(items_sent >= 700 && items_sent < 1000);
      pick = $urandom_range(99);
      if (pick < 68) begin
        if ($urandom_range(9) != 0) clear_beat();
        target = ($urandom_range(24) == 0) ? $urandom_range(64, 255) : $urandom_range(1, 31);
        build_preorder(target);
        foreach (preorder_q[i]) load_beat(preorder_q[i]);
        if ($urandom_range(9) == 0) load_beat(8'($urandom));
        repeat ($urandom_range(4, 60)) bit_beat(1'($urandom_range(1)));
      end else if (pick < 80) begin
        clear_beat();
        build_preorder($urandom_range(3, 31));
        cut = $urandom_range(preorder_q.size() - 1);
        for (int i = 0; i < cut; i++) load_beat(preorder_q[i]);
        repeat ($urandom_range(1, 3)) bit_beat(1'($urandom_range(1)));
        if ($urandom_range(1)) begin
          for (int i = cut; i < preorder_q.size(); i++) load_beat(preorder_q[i]);
          repeat ($urandom_range(2, 20)) bit_beat(1'($urandom_range(1)));
        end
      end else if (pick < 88) begin
        clear_beat();
        load_beat(leaf_byte());
        repeat ($urandom_range(1, 6)) bit_beat(1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 8))
          send_beat(2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)));
      end
    end

    // Drain: let the last expectation land, then give stray beats time to show.
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("prefix_tree_bit_decoder test passed");
    end else begin
      $display("prefix_tree_bit_decoder test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/ptbd_pkg.sv
sv/ptbd_ram.sv
sv/ptbd_ctrl.sv
sv/ptbd_dp.sv
sv/prefix_tree_bit_decoder.sv
sv/ptbd_checker.sv
test/prefix_tree_bit_decoder_checker.sv
test/prefix_tree_bit_decoder_tb.sv
